// ===== hw/rtl/lcm_pkg.sv =====
// ============================================================================
// lcm_pkg: shared types and constants for the linked chain manager
// Element count, field widths, command codes and sequencer states.
// ============================================================================
`default_nettype none

package lcm_pkg;

    // Number of elements held by the block (2..63); only 0..31 are addressable.
    localparam int ELEMENTS = 32;

    localparam int IDX_W   = 5;                   // element index field
    localparam int VAL_W   = 6;                   // result value field
    localparam int KIND_W  = 2;                   // command code field
    localparam int RUN_CAP = (ELEMENTS < 32) ? ELEMENTS : 32;
    localparam int TBL_DEPTH = RUN_CAP;           // addressable table entries

    // Counters share the 6-bit result width: steps stay below ELEMENTS, the rest reach at most RUN_CAP.
    localparam logic [VAL_W-1:0] ELEM_LIMIT = VAL_W'(ELEMENTS);
    localparam logic [VAL_W-1:0] CAP_LIMIT  = VAL_W'(RUN_CAP);

    typedef enum logic [KIND_W-1:0] {
        KIND_LINK   = 2'd0,
        KIND_UNLINK = 2'd1,
        KIND_REPORT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_COUNT,
        ST_LEN,
        ST_EMIT
    } t_state;

    // True when an index names an existing element.
    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        in_range = ({1'b0, idx} < ELEM_LIMIT);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcm_if.sv =====
// ============================================================================
// lcm_cmd_if / lcm_res_if: valid/ready channels of the linked chain manager
// Command channel carries link, unlink and report requests; result channel
// carries chain length and member indices.
// ============================================================================
`default_nettype none

interface lcm_cmd_if;
    import lcm_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  first_elem;
    logic [IDX_W-1:0]  second_elem;

    modport source (output valid, kind, first_elem, second_elem, input ready);
    modport sink   (input valid, kind, first_elem, second_elem, output ready);
endinterface

interface lcm_res_if;
    import lcm_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic             is_length;
    logic             last;

    modport source (output valid, value, is_length, last, input ready);
    modport sink   (input valid, value, is_length, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/linked_chain_manager.sv =====
// ============================================================================
// linked_chain_manager: doubly linked element chains with link/unlink/report
// Predecessor and successor tables with per-entry valid bits, walked by one
// shared link-follow unit under a small sequencer.
// ============================================================================
//
//  channel | dir | payload                           | transaction
//  --------+-----+-----------------------------------+------------------------
//  i_cmd   | in  | kind, first_elem, second_elem     | one command
//  o_res   | out | value, is_length, last            | one result of a report
//
//  Link and unlink commands complete in the cycle they are accepted.
//  A report holds the command input through all its steps, output stalls included:
//  accept, B backward steps and a final check, C count reads, the length, then C members
//  (B predecessor steps, at most ELEMENTS-1; C members, at most 32).
//  Reset clears all link valid bits at once; the block is ready right after.
//  A stalled result holds in the output register; the length and member emits wait on it.
//
`default_nettype none

module linked_chain_manager (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lcm_cmd_if.sink     i_cmd,
    lcm_res_if.source   o_res
);
    import lcm_pkg::*;

    // ------------------------------------------------------------------------
    // Link tables: index payload without reset, valid bits cleared by reset
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0] r_pred_idx [TBL_DEPTH];
    logic [IDX_W-1:0] r_succ_idx [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] r_pred_vld;
    logic [TBL_DEPTH-1:0] r_succ_vld;

    // Sequencer state and walk registers
    t_state           r_state,   n_state;
    logic [IDX_W-1:0] r_cur,     n_cur;      // element under the walk pointer
    logic [IDX_W-1:0] r_head,    n_head;     // head found by the backward walk
    logic [VAL_W-1:0] r_steps,   n_steps;    // backward steps taken
    logic [VAL_W-1:0] r_cnt,     n_cnt;      // chain length
    logic [VAL_W-1:0] r_emit,    n_emit;     // 1-based index of next member
    logic             r_solo,    n_solo;     // out-of-range report

    // Output register
    logic             r_out_vld, n_out_vld;
    logic [VAL_W-1:0] r_out_val, n_out_val;
    logic             r_out_len, n_out_len;
    logic             r_out_last, n_out_last;

    logic             cmd_acc;
    logic             slot_free;
    logic             link_ok;
    logic             sel_vld;
    logic [IDX_W-1:0] sel_idx;
    logic             step_ok;

    assign i_cmd.ready     = (r_state == ST_IDLE);
    assign cmd_acc         = i_cmd.valid && i_cmd.ready;
    assign slot_free       = !r_out_vld || o_res.ready;
    assign link_ok         = in_range(i_cmd.first_elem) && in_range(i_cmd.second_elem);

    assign o_res.valid     = r_out_vld;
    assign o_res.value     = r_out_val;
    assign o_res.is_length = r_out_len;
    assign o_res.last      = r_out_last;

    // ------------------------------------------------------------------------
    // Shared link-follow unit: read predecessor while walking back, successor
    // otherwise, and qualify the link.
    // ------------------------------------------------------------------------
    always_comb begin
        if (r_state == ST_BACK) begin
            sel_vld = r_pred_vld[r_cur];
            sel_idx = r_pred_idx[r_cur];
        end else begin
            sel_vld = r_succ_vld[r_cur];
            sel_idx = r_succ_idx[r_cur];
        end
        step_ok = sel_vld && in_range(sel_idx);
    end

    // ------------------------------------------------------------------------
    // Table updates: link sets both directions, unlink drops both
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred_vld <= '0;
            r_succ_vld <= '0;
        end else if (cmd_acc && link_ok) begin
            case (t_kind'(i_cmd.kind))
                KIND_LINK: begin
                    r_succ_vld[i_cmd.first_elem]  <= 1'b1;
                    r_pred_vld[i_cmd.second_elem] <= 1'b1;
                end
                KIND_UNLINK: begin
                    r_succ_vld[i_cmd.first_elem]  <= 1'b0;
                    r_pred_vld[i_cmd.second_elem] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc && link_ok && (t_kind'(i_cmd.kind) == KIND_LINK)) begin
            r_succ_idx[i_cmd.first_elem]  <= i_cmd.second_elem;
            r_pred_idx[i_cmd.second_elem] <= i_cmd.first_elem;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: walk back to the head, count forward, emit length, then emit
    // members along the same forward path; an out-of-range report emits only the length.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_head     = r_head;
        n_steps    = r_steps;
        n_cnt      = r_cnt;
        n_emit     = r_emit;
        n_solo     = r_solo;
        n_out_vld  = r_out_vld && !o_res.ready;
        n_out_val  = r_out_val;
        n_out_len  = r_out_len;
        n_out_last = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (cmd_acc && (t_kind'(i_cmd.kind) == KIND_REPORT)) begin
                    if (!in_range(i_cmd.first_elem)) begin
                        // Unknown element: report a lone empty chain
                        n_solo  = 1'b1;
                        n_cnt   = '0;
                        n_state = ST_LEN;
                    end else begin
                        n_solo  = 1'b0;
                        n_cur   = i_cmd.first_elem;
                        n_steps = '0;
                        n_state = ST_BACK;
                    end
                end
            end
            ST_BACK: begin
                // Bound the walk so a cycle of links cannot trap it
                if (((r_steps + 1'b1) < ELEM_LIMIT) && step_ok) begin
                    n_cur   = sel_idx;
                    n_steps = r_steps + 1'b1;
                end else begin
                    n_head  = r_cur;
                    n_cnt   = VAL_W'(1);
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                if ((r_cnt >= CAP_LIMIT) || !step_ok) begin
                    n_state = ST_LEN;
                end else begin
                    n_cur = sel_idx;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_LEN: begin
                if (slot_free) begin
                    n_out_vld  = 1'b1;
                    n_out_val  = r_cnt;
                    n_out_len  = 1'b1;
                    n_out_last = r_solo;
                    if (r_solo) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cur   = r_head;
                        n_emit  = VAL_W'(1);
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_vld  = 1'b1;
                    n_out_val  = {1'b0, r_cur};
                    n_out_len  = 1'b0;
                    n_out_last = (r_emit == r_cnt);
                    if (r_emit == r_cnt) begin
                        n_state = ST_IDLE;
                    end else begin
                        // Same path as the count pass, so the link is valid here
                        n_cur  = sel_idx;
                        n_emit = r_emit + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_cur     <= '0;
            r_solo    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_cur     <= n_cur;
            r_solo    <= n_solo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head     <= n_head;
        r_steps    <= n_steps;
        r_cnt      <= n_cnt;
        r_emit     <= n_emit;
        r_out_val  <= n_out_val;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A report in flight blocks new commands until its final result is out.
    a_busy_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.last) |-> !i_cmd.ready)
        else $error("command accepted while a report run is unfinished");

    // A reported length never exceeds the member cap.
    a_len_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_length) |-> (o_res.value <= CAP_LIMIT))
        else $error("reported chain length exceeds cap");

    // The emit pass never runs past the counted length.
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> ((r_emit <= r_cnt) && (r_emit != '0)))
        else $error("member emit index out of bounds");

    // No result survives reset.
    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
